### hdl/fpa_pkg.sv
package fpa_pkg;

  // Default sizing of the free-block table.
  localparam int MAX_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  // Fixed widths of the stream and configuration fields.
  localparam int IDX_BITS      = 4;
  localparam int VAL_BITS      = 16;
  localparam int TDATA_BITS    = 24;
  localparam int CFG_DATA_BITS = 5;
  localparam int CFG_IDX_BITS  = 1;

  // Reset value of the search count register.
  localparam logic [CFG_DATA_BITS-1:0] BLOCKS_RESET = 5'd16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_POLICY = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCKS = 1'b1;

  // Operation carried in the input tuser.
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PLACE = 1'b1
  } op_t;

  // Placement policy.
  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_NEXT  = 2'd1,
    POL_BEST  = 2'd2,
    POL_WORST = 2'd3
  } policy_t;

endpackage

### hdl/fpa_mem.sv
module fpa_mem #(
  parameter int DEPTH = fpa_pkg::MAX_BLOCKS_DEF,
  parameter int AW    = 4,
  parameter int DW    = fpa_pkg::SIZE_BITS_DEF
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [DEPTH];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### hdl/fpa_engine.sv
module fpa_engine #(
  parameter int MAX_BLOCKS = fpa_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpa_pkg::SIZE_BITS_DEF,
  parameter int IDX_W      = 4,
  parameter int CNT_W      = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration, stable while a transaction is in flight.
  input  fpa_pkg::policy_t               policy,
  input  logic [CNT_W-1:0]               search_cnt,
  // Input stream.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic                           in_tuser,
  input  logic [fpa_pkg::TDATA_BITS-1:0] in_tdata,
  // Result stream.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic                           out_tuser,
  output logic [fpa_pkg::TDATA_BITS-1:0] out_tdata,
  // Table memory.
  output logic                           mem_we,
  output logic [IDX_W-1:0]               mem_waddr,
  output logic [SIZE_BITS-1:0]           mem_wdata,
  output logic [IDX_W-1:0]               mem_raddr,
  input  logic [SIZE_BITS-1:0]           mem_rdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE
  } state_t;

  state_t                 state_r;
  fpa_pkg::policy_t       pol_r;
  logic [CNT_W-1:0]       n_r;
  logic [CNT_W-1:0]       k_r;
  logic [IDX_W-1:0]       pos_r;
  logic [IDX_W-1:0]       rover_r;
  logic [IDX_W-1:0]       pick_r;
  logic [SIZE_BITS-1:0]   req_r;
  logic [SIZE_BITS-1:0]   best_r;
  logic                   have_r;
  logic                   out_valid_r;
  logic                   out_placed_r;
  logic [fpa_pkg::IDX_BITS-1:0] out_block_r;
  logic [fpa_pkg::VAL_BITS-1:0] out_left_r;

  logic                          in_fire;
  logic                          in_is_load;
  logic [fpa_pkg::IDX_BITS-1:0]  in_idx;
  logic [fpa_pkg::VAL_BITS-1:0]  in_size;
  logic                          load_in_range;
  logic [IDX_W-1:0]              start_pos;
  logic [CNT_W-1:0]              pos_inc;
  logic [IDX_W-1:0]              next_pos;
  logic                          last_entry;
  logic                          fits;
  logic                          take;
  logic                          stop_early;
  logic                          update_go;
  logic [SIZE_BITS-1:0]          left_size;

  // Input transaction decode.
  assign in_tready     = (state_r == S_IDLE);
  assign in_fire       = in_tvalid && in_tready;
  assign in_is_load    = (fpa_pkg::op_t'(in_tuser) == fpa_pkg::OP_LOAD);
  assign in_idx        = in_tdata[fpa_pkg::IDX_BITS-1:0];
  assign in_size       = in_tdata[fpa_pkg::IDX_BITS +: fpa_pkg::VAL_BITS];
  assign load_in_range = (32'(in_idx) < MAX_BLOCKS);

  // Next fit resumes at the rover unless it lies beyond the search window.
  assign start_pos = ((policy == fpa_pkg::POL_NEXT) && (CNT_W'(rover_r) < search_cnt)) ?
                     rover_r : '0;

  // Circular walk over the search window.
  assign pos_inc    = CNT_W'(pos_r) + CNT_W'(1);
  assign next_pos   = (pos_inc >= n_r) ? '0 : IDX_W'(pos_inc);
  assign last_entry = (k_r == (n_r - CNT_W'(1)));

  // Compare the entry that the memory returns this cycle.
  assign fits = (mem_rdata >= req_r);
  always_comb begin
    take       = 1'b0;
    stop_early = 1'b0;
    case (pol_r) inside
      fpa_pkg::POL_FIRST, fpa_pkg::POL_NEXT: begin
        take       = fits;
        stop_early = fits;
      end
      fpa_pkg::POL_BEST: take = fits && (!have_r || (mem_rdata < best_r));
      fpa_pkg::POL_WORST: take = fits && (!have_r || (mem_rdata > best_r));
      default: take = 1'b0;
    endcase
  end

  // The update leaves only when the output register is free.
  assign update_go = (state_r == S_UPDATE) && (!out_valid_r || out_tready);
  assign left_size = best_r - req_r;

  // Memory port steering; the state machine keeps reads and writes apart.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pick_r;
    mem_wdata = left_size;
    mem_raddr = '0;
    if (in_fire && in_is_load) begin
      mem_we    = load_in_range;
      mem_waddr = IDX_W'(in_idx);
      mem_wdata = SIZE_BITS'(in_size);
    end else if (update_go) begin
      mem_we = have_r;
    end
    if (state_r == S_IDLE) begin
      mem_raddr = start_pos;
    end else if (state_r == S_SCAN) begin
      mem_raddr = next_pos;
    end
  end

  // Sequencer and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rover_r     <= '0;
    end else begin
      // A result that leaves without a new one behind it empties the register.
      if (out_valid_r && out_tready && !update_go) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_is_load) begin
              rover_r <= '0;
            end else begin
              pol_r  <= policy;
              n_r    <= search_cnt;
              req_r  <= SIZE_BITS'(in_size);
              pos_r  <= start_pos;
              k_r    <= '0;
              have_r <= 1'b0;
              if (search_cnt == '0) begin
                state_r <= S_UPDATE;
              end else begin
                if (policy == fpa_pkg::POL_NEXT) begin
                  rover_r <= start_pos;
                end
                state_r <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          if (take) begin
            have_r <= 1'b1;
            pick_r <= pos_r;
            best_r <= mem_rdata;
          end
          if (stop_early || last_entry) begin
            state_r <= S_UPDATE;
          end else begin
            pos_r <= next_pos;
            k_r   <= k_r + CNT_W'(1);
          end
        end
        S_UPDATE: begin
          if (update_go) begin
            out_valid_r  <= 1'b1;
            out_placed_r <= have_r;
            out_block_r  <= have_r ? fpa_pkg::IDX_BITS'(pick_r) : '0;
            out_left_r   <= have_r ? fpa_pkg::VAL_BITS'(left_size) : '0;
            if (have_r && (pol_r == fpa_pkg::POL_NEXT)) begin
              rover_r <= pick_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result stream outputs.
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_placed_r;
  assign out_tdata  = {{(fpa_pkg::TDATA_BITS - fpa_pkg::VAL_BITS - fpa_pkg::IDX_BITS){1'b0}},
                       out_left_r, out_block_r};

endmodule

### hdl/fit_placement_allocator_top.sv
// Free-block placement allocator. Load transactions (in_tuser = 0) write one
// entry of the free-size table and give no result; placement transactions
// (in_tuser = 1) pick a block under the policy register (first, next, best or
// worst fit, ties to the lowest index), shrink it by the request and return one
// result with the placed flag in out_tuser. The table sits in one memory with
// a single registered read port that the request scans one entry per cycle. It
// reads as many entries as the search count (saturated to MAX_BLOCKS), or fewer
// when first or next fit stops at a hit. A finished result waits in an output
// register while the next transaction is accepted. Table entries hold no value
// until loaded.
module fit_placement_allocator_top #(
  parameter int MAX_BLOCKS = fpa_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpa_pkg::SIZE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [fpa_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [fpa_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  // Input stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic                              in_tuser,   // [0] operation
  input  logic [fpa_pkg::TDATA_BITS-1:0]    in_tdata,   // [3:0] block_index, [19:4] size_value
  // Result stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic                              out_tuser,  // [0] placed
  output logic [fpa_pkg::TDATA_BITS-1:0]    out_tdata   // [3:0] chosen_block, [19:4] size_left
);

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  fpa_pkg::policy_t                  policy_r;
  logic [fpa_pkg::CFG_DATA_BITS-1:0] blocks_r;
  logic [CNT_W-1:0]                  search_cnt;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [SIZE_BITS-1:0] mem_wdata;
  logic [IDX_W-1:0]     mem_raddr;
  logic [SIZE_BITS-1:0] mem_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= fpa_pkg::POL_FIRST;
      blocks_r <= fpa_pkg::BLOCKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fpa_pkg::CFG_POLICY: policy_r <= fpa_pkg::policy_t'(cfg_wdata[1:0]);
        fpa_pkg::CFG_BLOCKS: blocks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Search count saturates at the table depth.
  assign search_cnt = (32'(blocks_r) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : CNT_W'(blocks_r);

  fpa_mem #(
    .DEPTH (MAX_BLOCKS),
    .AW    (IDX_W),
    .DW    (SIZE_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fpa_engine #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .policy     (policy_r),
    .search_cnt (search_cnt),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  // A load never produces a result.
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == fpa_pkg::OP_LOAD) && !out_tvalid) |=> !out_tvalid)
    else $error("result appeared after a load");

  // A request occupies the engine for at least the following cycle.
  a_place_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == fpa_pkg::OP_PLACE)) |=> !in_tready)
    else $error("engine accepted a transaction during a search");

  // A request that was not placed reports a zero block and size.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("not-placed result carries nonzero data");

endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH      = fpa_pkg::MAX_BLOCKS_DEF;
  localparam int PHASES           = 12;
  localparam int RANDOM_PER_PHASE = 60;
  localparam int SETTLE_CYCLES    = 24;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT      = 300000;

  typedef struct packed {
    fpa_pkg::op_t                 op;
    logic [fpa_pkg::IDX_BITS-1:0] index;
    logic [fpa_pkg::VAL_BITS-1:0] size;
  } alloc_cmd_t;

  typedef struct packed {
    logic                         placed;
    logic [fpa_pkg::IDX_BITS-1:0] block;
    logic [fpa_pkg::VAL_BITS-1:0] left;
  } placement_t;

  // Block ports; every input starts at a known value.
  logic                              clk        = 1'b0;
  logic                              rst_n      = 1'b0;
  logic                              cfg_we     = 1'b0;
  logic [fpa_pkg::CFG_IDX_BITS-1:0]  cfg_index  = '0;
  logic [fpa_pkg::CFG_DATA_BITS-1:0] cfg_wdata  = '0;
  logic                              in_tvalid  = 1'b0;
  logic                              in_tuser   = 1'b0;  // [0] operation
  logic [fpa_pkg::TDATA_BITS-1:0]    in_tdata   = '0;    // [3:0] block_index, [19:4] size_value
  logic                              out_tready = 1'b0;
  logic                              in_tready;
  logic                              out_tvalid;
  logic                              out_tuser;          // [0] placed
  logic [fpa_pkg::TDATA_BITS-1:0]    out_tdata;          // [3:0] chosen_block, [19:4] size_left

  // Shadow state of the allocator and its registers.
  logic [fpa_pkg::VAL_BITS-1:0] free_size [TABLE_DEPTH];
  int                           rover    = 0;
  fpa_pkg::policy_t             policy_q = fpa_pkg::POL_FIRST;
  logic [4:0]                   blocks_q = fpa_pkg::BLOCKS_RESET;

  alloc_cmd_t  pending_cmds[$];
  placement_t  placements_due[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Sender and receiver pacing.
  logic        in_taken    = 1'b0;
  int          burst_left  = 1;
  int          gap_left    = 0;
  int unsigned rx_cycle    = 0;
  int          hold_left   = 0;
  logic        hold_armed  = 1'b0;
  logic        hold_done   = 1'b0;

  fpa_pkg::policy_t phase_pol [PHASES];
  logic [4:0]       phase_blk [PHASES];

  fit_placement_allocator_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up if the run does not finish in time.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Serve one placement request on the shadow table and queue its result.
  task automatic place_request(input logic [fpa_pkg::VAL_BITS-1:0] req);
    int         n;
    int         k;
    int         pos;
    int         pick;
    placement_t res;
    n    = (blocks_q > TABLE_DEPTH) ? TABLE_DEPTH : int'(blocks_q);
    pick = -1;
    if (policy_q == fpa_pkg::POL_NEXT && n != 0) begin
      // A rover beyond the search count restarts the scan at entry 0.
      pos   = (rover < n) ? rover : 0;
      rover = pos;
      k     = 0;
      while (k < n && pick < 0) begin
        if (free_size[pos] >= req) begin
          pick = pos;
        end else begin
          pos = (pos + 1 >= n) ? 0 : pos + 1;
        end
        k++;
      end
      if (pick >= 0) begin
        rover = pick;
      end
    end else if (policy_q != fpa_pkg::POL_NEXT) begin
      // Strict comparisons keep ties on the lowest index.
      for (k = 0; k < n; k++) begin
        if (free_size[k] >= req) begin
          if (pick < 0) begin
            pick = k;
          end else if (policy_q == fpa_pkg::POL_BEST &&
                       free_size[k] < free_size[pick]) begin
            pick = k;
          end else if (policy_q == fpa_pkg::POL_WORST &&
                       free_size[k] > free_size[pick]) begin
            pick = k;
          end
        end
      end
    end
    res = '0;
    if (pick >= 0) begin
      free_size[pick] = free_size[pick] - req;
      res.placed      = 1'b1;
      res.block       = pick[fpa_pkg::IDX_BITS-1:0];
      res.left        = free_size[pick];
    end
    placements_due.push_back(res);
  endtask

  task automatic push_cmd(input fpa_pkg::op_t op, input logic [fpa_pkg::IDX_BITS-1:0] index,
                          input logic [fpa_pkg::VAL_BITS-1:0] size);
    alloc_cmd_t cmd;
    cmd.op    = op;
    cmd.index = index;
    cmd.size  = size;
    pending_cmds.push_back(cmd);
  endtask

  // Both registers are written back to back while the block is idle.
  task automatic write_config(input fpa_pkg::policy_t pol, input logic [4:0] blocks);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= fpa_pkg::CFG_POLICY;
    cfg_wdata <= fpa_pkg::CFG_DATA_BITS'(pol);
    @(negedge clk);
    cfg_index <= fpa_pkg::CFG_BLOCKS;
    cfg_wdata <= blocks;
    @(negedge clk);
    cfg_we   <= 1'b0;
    policy_q = pol;
    blocks_q = blocks;
  endtask

  // Input driver: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    alloc_cmd_t cmd;
    if (rst_n && !(in_tvalid && !in_taken)) begin
      if (gap_left > 0 || pending_cmds.size() == 0) begin
        in_tvalid <= 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end
      end else begin
        cmd = pending_cmds.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= cmd.op;
        in_tdata  <= {{(fpa_pkg::TDATA_BITS - fpa_pkg::VAL_BITS - fpa_pkg::IDX_BITS){1'b0}},
                      cmd.size, cmd.index};
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Result receiver: a stall pattern that steps through four modes in turn, plus one
  // long hold-off that backs the block up into its input.
  always @(negedge clk) begin
    rx_cycle++;
    if (hold_armed && !hold_done) begin
      hold_left = LONG_HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case ((rx_cycle / 256) % 4)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // Monitor: update the shadow table on every input transaction and check
  // every result transaction against the oldest expected placement.
  always @(posedge clk) begin
    placement_t want;
    in_taken <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      if (fpa_pkg::op_t'(in_tuser) == fpa_pkg::OP_LOAD) begin
        free_size[in_tdata[fpa_pkg::IDX_BITS-1:0]] =
          in_tdata[fpa_pkg::IDX_BITS +: fpa_pkg::VAL_BITS];
        rover = 0;
      end else begin
        place_request(in_tdata[fpa_pkg::IDX_BITS +: fpa_pkg::VAL_BITS]);
      end
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (placements_due.size() == 0) begin
        $display("%0t: unexpected result transaction, placed %0d block %0d left %0d",
                 $time, out_tuser, out_tdata[fpa_pkg::IDX_BITS-1:0],
                 out_tdata[fpa_pkg::IDX_BITS +: fpa_pkg::VAL_BITS]);
        mismatch_count++;
      end else begin
        want = placements_due.pop_front();
        if (out_tuser !== want.placed) begin
          $display("%0t: placed expected %0d actual %0d", $time, want.placed, out_tuser);
          mismatch_count++;
        end
        if (out_tdata[fpa_pkg::IDX_BITS-1:0] !== want.block) begin
          $display("%0t: chosen_block expected %0d actual %0d",
                   $time, want.block, out_tdata[fpa_pkg::IDX_BITS-1:0]);
          mismatch_count++;
        end
        if (out_tdata[fpa_pkg::IDX_BITS +: fpa_pkg::VAL_BITS] !== want.left) begin
          $display("%0t: size_left expected %0d actual %0d",
                   $time, want.left, out_tdata[fpa_pkg::IDX_BITS +: fpa_pkg::VAL_BITS]);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus: one phase per register setting, each with random traffic.
  initial begin
    int         p;
    int         i;
    alloc_cmd_t cmd;
    phase_pol = '{fpa_pkg::POL_FIRST, fpa_pkg::POL_NEXT, fpa_pkg::POL_NEXT,
                  fpa_pkg::POL_BEST, fpa_pkg::POL_WORST, fpa_pkg::POL_FIRST,
                  fpa_pkg::POL_BEST, fpa_pkg::POL_WORST, fpa_pkg::POL_NEXT,
                  fpa_pkg::POL_BEST, fpa_pkg::POL_WORST, fpa_pkg::POL_FIRST};
    phase_blk = '{5'd16, 5'd16, 5'd4, 5'd16, 5'd16, 5'd1,
                  5'd0, 5'd31, 5'd9, 5'd7, 5'd1, 5'd12};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (p = 0; p < PHASES; p++) begin
      write_config(phase_pol[p], phase_blk[p]);

      if (p == 0) begin
        // Fill every entry before any request can read it.
        for (i = 0; i < TABLE_DEPTH; i++) begin
          push_cmd(fpa_pkg::OP_LOAD, fpa_pkg::IDX_BITS'(i),
                   (i == 1) ? 16'hFFFF : (i == 2) ? 16'h0000 :
                   fpa_pkg::VAL_BITS'(i * 997 + 40));
        end
        push_cmd(fpa_pkg::OP_PLACE, 4'hF, 16'h0000);  // zero-size request
        push_cmd(fpa_pkg::OP_PLACE, 4'h0, 16'hFFFF);  // exact fit of the full-size block
        push_cmd(fpa_pkg::OP_PLACE, 4'h5, 16'hFFFF);  // nothing is large enough any more
        push_cmd(fpa_pkg::OP_PLACE, 4'hA, 16'd1000);
      end

      // The rover left high by the previous phase is stale under a search
      // count of 4, so next fit must restart at entry 0.
      if (p == 2) begin
        push_cmd(fpa_pkg::OP_PLACE, 4'h0, 16'd1);
      end

      if (p == 3) begin
        hold_armed = 1'b1;
      end

      // Mostly requests, with loads to refill the table now and then.
      for (i = 0; i < RANDOM_PER_PHASE; i++) begin
        cmd.index = fpa_pkg::IDX_BITS'($urandom_range(0, 15));
        if ($urandom_range(0, 3) == 0) begin
          cmd.op = fpa_pkg::OP_LOAD;
          case ($urandom_range(0, 9))
            0: cmd.size = '0;
            1: cmd.size = '1;
            default: cmd.size = fpa_pkg::VAL_BITS'($urandom_range(0, 65535));
          endcase
        end else begin
          cmd.op = fpa_pkg::OP_PLACE;
          case ($urandom_range(0, 11))
            0: cmd.size = '0;
            1: cmd.size = '1;
            default: cmd.size = fpa_pkg::VAL_BITS'(
                       $urandom_range(0, (32'd1 << $urandom_range(1, 16)) - 1));
          endcase
        end
        pending_cmds.push_back(cmd);
      end

      // Park the next-fit rover on a high block, then miss from there.
      if (p == 1) begin
        push_cmd(fpa_pkg::OP_LOAD, 4'd13, 16'hFFFF);
        push_cmd(fpa_pkg::OP_PLACE, 4'h3, 16'hFFFF);
        push_cmd(fpa_pkg::OP_PLACE, 4'hC, 16'hFFFF);
      end

      // Drain: all commands accepted, all results back, block settled.
      while (pending_cmds.size() != 0 || in_tvalid || placements_due.size() != 0) begin
        @(posedge clk);
      end
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/fpa_pkg.sv
hdl/fpa_mem.sv
hdl/fpa_engine.sv
hdl/fit_placement_allocator_top.sv
tb/testbench.sv
